// ----- rtl/pfx_pkg.sv -----
package pfx_pkg;

   localparam int BYTE_W  = 8;
   localparam int CNT_W   = $clog2(BYTE_W);
   localparam int LIMIT_W = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

   localparam logic [BYTE_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] SYM_TIMES = 8'h2A;
   localparam logic [BYTE_W-1:0] SYM_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] SYM_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] SYM_NINE  = 8'h39;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;
   localparam logic [1:0] ST_DIVZ  = 2'd3;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_R,
      S_GET_R,
      S_POP_L,
      S_GET_L,
      S_EXEC,
      S_WAIT,
      S_PUSH,
      S_FIN_POP,
      S_FIN_GET,
      S_FIN_OUT
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] symbol;
      logic              end_of_expression;
   } req_type;

   typedef struct packed {
      logic signed [BYTE_W-1:0] value;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      logic              start;
      alu_op_type        op;
      logic [BYTE_W-1:0] lhs;
      logic [BYTE_W-1:0] rhs;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic              div_zero;
      logic [BYTE_W-1:0] result;
   } alu_rsp_type;

endpackage

// ----- rtl/pfx_ram.sv -----
module pfx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pfx_alu.sv -----
module pfx_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  pfx_pkg::alu_req_type alu_req,
   output pfx_pkg::alu_rsp_type alu_rsp
);

   logic [pfx_pkg::BYTE_W-1:0] a_ff, a_in;
   logic [pfx_pkg::BYTE_W-1:0] b_ff, b_in;
   logic [pfx_pkg::BYTE_W-1:0] acc_ff, acc_in;
   logic [pfx_pkg::BYTE_W-1:0] rem_ff, rem_in;
   logic [pfx_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   pfx_pkg::alu_op_type        op_ff, op_in;
   logic                       carry_ff, carry_in;
   logic                       neg_ff, neg_in;
   logic                       divz_ff, divz_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   logic [pfx_pkg::BYTE_W-1:0] l_mag;
   logic [pfx_pkg::BYTE_W-1:0] r_mag;
   logic [pfx_pkg::BYTE_W-1:0] trial;
   logic                       sum_bit;

   localparam logic [pfx_pkg::CNT_W-1:0] CNT_LAST = pfx_pkg::CNT_W'(pfx_pkg::BYTE_W - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
      carry_ff <= carry_in;
      neg_ff   <= neg_in;
      divz_ff  <= divz_in;
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      carry_in = carry_ff;
      neg_in   = neg_ff;
      divz_in  = divz_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      l_mag    = alu_req.lhs[pfx_pkg::BYTE_W-1] ? -alu_req.lhs : alu_req.lhs;
      r_mag    = alu_req.rhs[pfx_pkg::BYTE_W-1] ? -alu_req.rhs : alu_req.rhs;
      trial    = {rem_ff[pfx_pkg::BYTE_W-2:0], a_ff[pfx_pkg::BYTE_W-1]};
      sum_bit  = a_ff[0] ^ b_ff[0] ^ carry_ff;

      if (alu_req.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         op_in    = alu_req.op;
         acc_in   = '0;
         rem_in   = '0;
         a_in     = alu_req.lhs;
         b_in     = alu_req.rhs;
         carry_in = 1'b0;
         neg_in   = alu_req.lhs[pfx_pkg::BYTE_W-1] ^ alu_req.rhs[pfx_pkg::BYTE_W-1];
         divz_in  = (alu_req.rhs == '0);
         case (alu_req.op)
            pfx_pkg::ALU_SUB: begin
               b_in     = ~alu_req.rhs;
               carry_in = 1'b1;
            end
            pfx_pkg::ALU_DIV: begin
               a_in = l_mag;
               b_in = r_mag;
            end
            default: begin
            end
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         case (op_ff)
            pfx_pkg::ALU_ADD, pfx_pkg::ALU_SUB: begin
               // One sum bit per cycle, least significant first.
               carry_in = (a_ff[0] & b_ff[0]) | (carry_ff & (a_ff[0] ^ b_ff[0]));
               acc_in   = {sum_bit, acc_ff[pfx_pkg::BYTE_W-1:1]};
               a_in     = a_ff >> 1;
               b_in     = b_ff >> 1;
            end
            pfx_pkg::ALU_MUL: begin
               // Only the low byte of the product is kept, so signs need no care.
               if (b_ff[0]) begin
                  acc_in = acc_ff + a_ff;
               end
               a_in = a_ff << 1;
               b_in = b_ff >> 1;
            end
            pfx_pkg::ALU_DIV: begin
               // Restoring division on magnitudes, one quotient bit per cycle.
               if (trial >= b_ff) begin
                  rem_in = trial - b_ff;
                  acc_in = {acc_ff[pfx_pkg::BYTE_W-2:0], 1'b1};
               end else begin
                  rem_in = trial;
                  acc_in = {acc_ff[pfx_pkg::BYTE_W-2:0], 1'b0};
               end
               a_in = a_ff << 1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      alu_rsp.done     = done_ff;
      alu_rsp.div_zero = (op_ff == pfx_pkg::ALU_DIV) && divz_ff;
      alu_rsp.result   = acc_ff;
      if (op_ff == pfx_pkg::ALU_DIV) begin
         if (divz_ff) begin
            alu_rsp.result = '0;
         end else if (neg_ff) begin
            alu_rsp.result = -acc_ff;
         end
      end
   end

endmodule

// ----- rtl/postfix_expression_evaluator.sv -----
// Channel   Direction  Handshake                 Word
// req_      in         req_valid / req_ready     req_data: symbol, end_of_expression
// rsp_      out        rsp_valid / rsp_ready     rsp_data: value, status
// csr_      in         csr_wr_en, no wait        csr_wr_data: stack_limit
//
// A digit or other non-operator character goes from idle to the push state and back. An
// operator with both operands on the stack pops and reads each one, then starts the
// bit-serial arithmetic unit and waits while it works one bit of the byte per cycle, then
// pushes the result. A pop from an empty stack skips its read state and flags underflow.
// The word marked last adds a final read of the top of the stack before the result is loaded.
// Reset is synchronous: stack empty, no error, stack_limit back to 10.
// A stalled result sits in the output register while the next expression is taken;
// only a second finished result waits for it, holding req_ready low.
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pfx_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pfx_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [pfx_pkg::LIMIT_W-1:0]         csr_wr_data
);

   localparam int AW    = $clog2(STACK_DEPTH);
   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W = (SP_W > pfx_pkg::LIMIT_W) ? SP_W : pfx_pkg::LIMIT_W;
   localparam logic [SP_W-1:0] DEPTH_C = SP_W'(STACK_DEPTH);

   pfx_pkg::state_type         state_ff, state_in;
   logic [SP_W-1:0]            sp_ff, sp_in;
   logic [1:0]                 err_ff, err_in;
   logic [pfx_pkg::LIMIT_W-1:0] limit_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   pfx_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic                       last_ff, last_in;
   pfx_pkg::alu_op_type        op_ff, op_in;
   logic [pfx_pkg::BYTE_W-1:0] opnd_r_ff, opnd_r_in;
   logic [pfx_pkg::BYTE_W-1:0] opnd_l_ff, opnd_l_in;
   logic [pfx_pkg::BYTE_W-1:0] push_ff, push_in;

   logic                       wr_en;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [pfx_pkg::BYTE_W-1:0] rd_data;
   logic [SP_W-1:0]            sp_dec;
   logic                       full;
   logic                       out_free;
   pfx_pkg::alu_req_type       alu_req;
   pfx_pkg::alu_rsp_type       alu_rsp;

   pfx_ram #(
      .WIDTH (pfx_pkg::BYTE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sp_ff[AW-1:0]),
      .wr_data (push_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfx_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign sp_dec   = sp_ff - 1'b1;
   assign rd_addr  = sp_dec[AW-1:0];
   assign full     = (CMP_W'(sp_ff) >= CMP_W'(limit_ff)) || (sp_ff >= DEPTH_C);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == pfx_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfx_pkg::S_IDLE;
         sp_ff        <= '0;
         err_ff       <= pfx_pkg::ST_OK;
         limit_ff     <= pfx_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      last_ff     <= last_in;
      op_ff       <= op_in;
      opnd_r_ff   <= opnd_r_in;
      opnd_l_ff   <= opnd_l_in;
      push_ff     <= push_in;
   end

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      last_in      = last_ff;
      op_in        = op_ff;
      opnd_r_in    = opnd_r_ff;
      opnd_l_in    = opnd_l_ff;
      push_in      = push_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      alu_req      = '{start: 1'b0, op: op_ff, lhs: opnd_l_ff, rhs: opnd_r_ff};

      case (state_ff)
         pfx_pkg::S_IDLE: begin
            if (req_valid) begin
               last_in = req_data.end_of_expression;
               push_in = '0;
               state_in = pfx_pkg::S_PUSH;
               if (req_data.symbol inside {pfx_pkg::SYM_PLUS, pfx_pkg::SYM_MINUS,
                                           pfx_pkg::SYM_TIMES, pfx_pkg::SYM_SLASH}) begin
                  state_in = pfx_pkg::S_POP_R;
                  case (req_data.symbol)
                     pfx_pkg::SYM_PLUS:  op_in = pfx_pkg::ALU_ADD;
                     pfx_pkg::SYM_MINUS: op_in = pfx_pkg::ALU_SUB;
                     pfx_pkg::SYM_TIMES: op_in = pfx_pkg::ALU_MUL;
                     default:            op_in = pfx_pkg::ALU_DIV;
                  endcase
               end else if (req_data.symbol inside {[pfx_pkg::SYM_ZERO:pfx_pkg::SYM_NINE]}) begin
                  push_in = req_data.symbol - pfx_pkg::SYM_ZERO;
               end
            end
         end
         pfx_pkg::S_POP_R: begin
            if (sp_ff == '0) begin
               opnd_r_in = '0;
               if (err_ff == pfx_pkg::ST_OK) err_in = pfx_pkg::ST_UNDER;
               state_in = pfx_pkg::S_POP_L;
            end else begin
               rd_en    = 1'b1;
               sp_in    = sp_dec;
               state_in = pfx_pkg::S_GET_R;
            end
         end
         pfx_pkg::S_GET_R: begin
            opnd_r_in = rd_data;
            state_in  = pfx_pkg::S_POP_L;
         end
         pfx_pkg::S_POP_L: begin
            if (sp_ff == '0) begin
               opnd_l_in = '0;
               if (err_ff == pfx_pkg::ST_OK) err_in = pfx_pkg::ST_UNDER;
               state_in = pfx_pkg::S_EXEC;
            end else begin
               rd_en    = 1'b1;
               sp_in    = sp_dec;
               state_in = pfx_pkg::S_GET_L;
            end
         end
         pfx_pkg::S_GET_L: begin
            opnd_l_in = rd_data;
            state_in  = pfx_pkg::S_EXEC;
         end
         pfx_pkg::S_EXEC: begin
            alu_req.start = 1'b1;
            state_in      = pfx_pkg::S_WAIT;
         end
         pfx_pkg::S_WAIT: begin
            if (alu_rsp.done) begin
               push_in = alu_rsp.result;
               if (alu_rsp.div_zero && (err_ff == pfx_pkg::ST_OK)) err_in = pfx_pkg::ST_DIVZ;
               state_in = pfx_pkg::S_PUSH;
            end
         end
         pfx_pkg::S_PUSH: begin
            if (full) begin
               if (err_ff == pfx_pkg::ST_OK) err_in = pfx_pkg::ST_OVER;
            end else begin
               wr_en = 1'b1;
               sp_in = sp_ff + 1'b1;
            end
            state_in = last_ff ? pfx_pkg::S_FIN_POP : pfx_pkg::S_IDLE;
         end
         pfx_pkg::S_FIN_POP: begin
            if (sp_ff == '0) begin
               opnd_r_in = '0;
               if (err_ff == pfx_pkg::ST_OK) err_in = pfx_pkg::ST_UNDER;
               state_in = pfx_pkg::S_FIN_OUT;
            end else begin
               rd_en    = 1'b1;
               state_in = pfx_pkg::S_FIN_GET;
            end
         end
         pfx_pkg::S_FIN_GET: begin
            opnd_r_in = rd_data;
            state_in  = pfx_pkg::S_FIN_OUT;
         end
         pfx_pkg::S_FIN_OUT: begin
            // Entries left below the top are discarded along with the pointer.
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.value  = opnd_r_ff;
               rsp_data_in.status = err_ff;
               sp_in              = '0;
               err_in             = pfx_pkg::ST_OK;
               state_in           = pfx_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pfx_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/pfx_checker.sv -----
module pfx_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input pfx_pkg::req_type            req_data,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input pfx_pkg::rsp_type            rsp_data
);

   logic [1:0] owed_ff, owed_in;
   logic       last_acc;
   logic       rsp_acc;

   assign last_acc = req_valid && req_ready && req_data.end_of_expression;
   assign rsp_acc  = rsp_valid && rsp_ready;

   // Counts expressions whose last word is in but whose result is not yet taken.
   always_comb begin
      owed_in = owed_ff;
      if (last_acc && !rsp_acc) begin
         owed_in = owed_ff + 1'b1;
      end else if (rsp_acc && !last_acc) begin
         owed_in = owed_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else begin
         owed_ff <= owed_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> owed_ff != 2'd0)
      else $error("result word without a finished expression");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken on consecutive cycles");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty and ready after reset");

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (.*);
